// ===== hw/rtl/sha1he_pkg.sv =====
// Shared constants and types of the SHA-1 hash engine.
package sha1he_pkg;

    localparam int unsigned WordWidth  = 32;
    localparam int unsigned HashWords  = 5;
    localparam int unsigned BlockBits  = 512;
    localparam int unsigned Rounds     = 80;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [6:0] LastRound = 7'd79;
    localparam logic [2:0] LastWord  = 3'd4;
    localparam logic [5:0] LastByte  = 6'd63;
    localparam logic [5:0] LenStart  = 6'd56;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = IV0;
            3'd1:    v = IV1;
            3'd2:    v = IV2;
            3'd3:    v = IV3;
            default: v = IV4;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/sha1_hash_engine_top.sv =====
// Top level of the SHA-1 hash engine: byte buffer, padding sequencer and round unit.

// The engine hashes a byte stream with standard SHA-1. Each input transaction carries at
// most one message byte (tuser[0] says whether tdata holds one) and may end the message
// with tlast. Bytes are accepted only while the engine is idle; the sixty-fourth byte of a
// block starts the compression, which runs one round per cycle through a single round unit
// and then folds the working words into the chaining words, with s_tready low throughout.
// At the end of a message the sequencer appends the 0x80 pad byte, zero fill and the 64-bit
// big-endian bit length one byte per cycle, compressing once or twice. The digest leaves
// as five 32-bit transactions, most significant word first, the fifth with tlast set; the
// engine then returns to the initial vector for the next message.
module sha1_hash_engine_top
    import sha1he_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast    // last_word
);

    state_t state_reg, state_next;

    // The block buffer is a shift line of bytes; during the rounds it doubles as the
    // sixteen-word window of the message schedule.
    logic [BlockBits-1:0] blk_reg, blk_next;
    logic [WordWidth-1:0] h_reg [HashWords];
    logic [WordWidth-1:0] h_next [HashWords];
    logic [WordWidth-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WordWidth-1:0] a_next, b_next, c_next, d_next, e_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [2:0]  widx_reg, widx_next;
    logic        pad_reg, pad_next;         // message ended, padding still to finish
    logic        first_reg, first_next;     // the 0x80 byte is still to be written
    logic        fin_blk_reg, fin_blk_next; // the current block carries the length
    logic        done_reg, done_next;       // the block being compressed is the last one

    logic        s_fire, m_fire;
    logic        app_en;
    logic [7:0]  app_byte;
    logic [7:0]  len_byte;

    // Round unit signals.
    logic [WordWidth-1:0] w0, w2, w8, w13, wi, f_val, k_val, t_val;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_fire   = m_tvalid && m_tready;
    assign m_tdata  = h_reg[widx_reg];
    assign m_tlast  = (widx_reg == LastWord);

    // Length bytes go in most significant first, positions 56 to 63 of the final block.
    assign len_byte = 8'(len_reg >> {3'd7 - fill_reg[2:0], 3'b000});

    assign w0  = blk_reg[BlockBits-1 -: WordWidth];
    assign w2  = blk_reg[BlockBits-1-2*WordWidth -: WordWidth];
    assign w8  = blk_reg[BlockBits-1-8*WordWidth -: WordWidth];
    assign w13 = blk_reg[BlockBits-1-13*WordWidth -: WordWidth];

    always_comb
    begin
        logic [WordWidth-1:0] x;
        x  = w13 ^ w8 ^ w2 ^ w0;
        wi = (rnd_reg < 7'd16) ? w0 : {x[WordWidth-2:0], x[WordWidth-1]};
        if (rnd_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
        t_val = {a_reg[WordWidth-6:0], a_reg[WordWidth-1:WordWidth-5]}
              + f_val + e_reg + k_val + wi;
    end

    always_comb
    begin
        state_next   = state_reg;
        blk_next     = blk_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        rnd_next     = rnd_reg;
        widx_next    = widx_reg;
        pad_next     = pad_reg;
        first_next   = first_reg;
        fin_blk_next = fin_blk_reg;
        done_next    = done_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        e_next       = e_reg;
        for (int i = 0; i < HashWords; i++)
        begin
            h_next[i] = h_reg[i];
        end
        app_en   = 1'b0;
        app_byte = s_tdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    app_en   = s_tuser[0];
                    app_byte = s_tdata;
                    if (s_tuser[0])
                    begin
                        len_next = len_reg + 64'd8;
                    end
                    if (s_tlast)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        state_next = ST_PAD;
                    end
                    if (s_tuser[0] && fill_reg == LastByte)
                    begin
                        done_next  = 1'b0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_PAD:
            begin
                app_en = 1'b1;
                if (first_reg)
                begin
                    app_byte     = PadByte;
                    first_next   = 1'b0;
                    fin_blk_next = (fill_reg < LenStart);
                end
                else if (fin_blk_reg && fill_reg >= LenStart)
                begin
                    app_byte = len_byte;
                end
                else
                begin
                    app_byte = 8'h00;
                end
                if (fill_reg == LastByte)
                begin
                    done_next  = first_reg ? 1'b0 : fin_blk_reg;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                blk_next = {blk_reg[BlockBits-WordWidth-1:0], wi};
                e_next   = d_reg;
                d_next   = c_reg;
                c_next   = {b_reg[1:0], b_reg[WordWidth-1:2]};
                b_next   = a_reg;
                a_next   = t_val;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == LastRound)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                h_next[4] = h_reg[4] + e_reg;
                if (done_reg)
                begin
                    widx_next  = 3'd0;
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    fin_blk_next = 1'b1;
                    state_next   = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (m_fire)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == LastWord)
                    begin
                        for (int i = 0; i < HashWords; i++)
                        begin
                            h_next[i] = iv_word(3'(i));
                        end
                        fill_next  = 6'd0;
                        len_next   = 64'd0;
                        pad_next   = 1'b0;
                        done_next  = 1'b0;
                        widx_next  = 3'd0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (app_en)
        begin
            blk_next  = {blk_reg[BlockBits-9:0], app_byte};
            fill_next = fill_reg + 6'd1;
        end

        // Load the working words as a block goes into the round unit.
        if (state_reg != ST_ROUND && state_next == ST_ROUND)
        begin
            a_next   = h_reg[0];
            b_next   = h_reg[1];
            c_next   = h_reg[2];
            d_next   = h_reg[3];
            e_next   = h_reg[4];
            rnd_next = 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= 6'd0;
            len_reg     <= 64'd0;
            rnd_reg     <= 7'd0;
            widx_reg    <= 3'd0;
            pad_reg     <= 1'b0;
            first_reg   <= 1'b0;
            fin_blk_reg <= 1'b0;
            done_reg    <= 1'b0;
            for (int i = 0; i < HashWords; i++)
            begin
                h_reg[i] <= iv_word(3'(i));
            end
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            rnd_reg     <= rnd_next;
            widx_reg    <= widx_next;
            pad_reg     <= pad_next;
            first_reg   <= first_next;
            fin_blk_reg <= fin_blk_next;
            done_reg    <= done_next;
            for (int i = 0; i < HashWords; i++)
            begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

endmodule
